@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/tpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// tpbm_pkg
// Shared types and constants of the TS per-PID payload bitrate meter.
// ----------------------------------------------------------------------------
package tpbm_pkg;

  // Transport packet constants
  localparam logic [7:0] SYNC_VALUE   = 8'h47;
  localparam logic [8:0] TS_SIZE      = 9'd188;
  localparam logic [8:0] ADAPT_BASE   = 9'd5;     // 4 header bytes + length byte
  localparam logic [7:0] FULL_PAYLOAD = 8'd184;

  // Adaptation field control codes
  localparam logic [1:0] AFC_PAYLOAD_ONLY  = 2'd1;
  localparam logic [1:0] AFC_ADAPT_PAYLOAD = 2'd3;

  // Commands and result kinds
  localparam logic CMD_COUNT   = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PID_SLOT0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PID_SLOT3    = 3'd5;

  // Rate arithmetic: bytes * 8 * 45000, 96-bit numerator, 32-bit divisor
  localparam int BITS_PER_BYTE = 8;
  localparam int TICK_RATE     = 45000;
  localparam int MULT_W        = 19;
  localparam logic [MULT_W-1:0] RATE_MULT = MULT_W'(BITS_PER_BYTE * TICK_RATE);
  localparam int NUM_W  = 96;
  localparam int QUO_W  = 64;
  localparam int DUR_W  = 32;
  localparam int STEP_W = 7;
  localparam logic [4:0]        MUL_IDX_TOP = 5'(MULT_W - 1);
  localparam logic [STEP_W-1:0] MUL_LAST    = STEP_W'(MULT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(QUO_W - 1);

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_ACCUM,
    ST_PKT_OUT,
    ST_RPT_LOAD,
    ST_MUL,
    ST_ROUND,
    ST_SATCHK,
    ST_DIV,
    ST_RPT_OUT
  } state_t;

  typedef struct packed {
    logic [12:0] pid;
    logic [7:0]  size;
  } hdr_info_t;

  typedef struct packed {
    logic [NUM_W-1:0] sum;
    logic             carry;   // carry out; for subtract, a >= b
  } alu_res_t;

endpackage

@@ rtl/tpbm_hdr_decode.sv @@
// ----------------------------------------------------------------------------
// tpbm_hdr_decode
// Sync check, PID extraction and payload size of one TS packet header.
// ----------------------------------------------------------------------------
module tpbm_hdr_decode (
  input  logic [7:0]          sync_byte,
  input  logic [7:0]          hdr_byte1,
  input  logic [7:0]          hdr_byte2,
  input  logic [7:0]          hdr_byte3,
  input  logic [7:0]          adapt_len,
  output tpbm_pkg::hdr_info_t info
);
  import tpbm_pkg::*;

  logic       sync_ok;
  logic [1:0] afc;
  logic [8:0] adapt_end;

  assign sync_ok   = (sync_byte == SYNC_VALUE);
  assign afc       = hdr_byte3[5:4];
  assign adapt_end = ADAPT_BASE + {1'b0, adapt_len};

  // Bad sync gives zero PID and size
  always_comb begin
    info.pid  = '0;
    info.size = '0;
    if (sync_ok) begin
      info.pid = {hdr_byte1[4:0], hdr_byte2};
      unique case (afc)
        AFC_PAYLOAD_ONLY: info.size = FULL_PAYLOAD;
        AFC_ADAPT_PAYLOAD: begin
          if (adapt_end < TS_SIZE) begin
            info.size = 8'(TS_SIZE - adapt_end);
          end
        end
        default: info.size = '0;
      endcase
    end
  end

endmodule

@@ rtl/tpbm_alu.sv @@
// ----------------------------------------------------------------------------
// tpbm_alu
// Shared 96-bit add/subtract unit used by the accumulate, multiply, round, saturation-check and divide steps.
// ----------------------------------------------------------------------------
module tpbm_alu (
  input  tpbm_pkg::alu_op_t              op,
  input  logic [tpbm_pkg::NUM_W-1:0]     a,
  input  logic [tpbm_pkg::NUM_W-1:0]     b,
  output tpbm_pkg::alu_res_t             res
);
  import tpbm_pkg::*;

  logic [NUM_W-1:0] b_eff;
  logic             cin;
  logic [NUM_W:0]   full;

  // Subtract as a + ~b + 1
  always_comb begin
    b_eff = b;
    cin   = 1'b0;
    unique case (op)
      ALU_ADD: begin
        b_eff = b;
        cin   = 1'b0;
      end
      ALU_SUB: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
    endcase
  end

  assign full      = {1'b0, a} + {1'b0, b_eff} + {{NUM_W{1'b0}}, cin};
  assign res.sum   = full[NUM_W-1:0];
  assign res.carry = full[NUM_W];

endmodule

@@ rtl/ts_pid_payload_bitrate_meter.sv @@
// ----------------------------------------------------------------------------
// ts_pid_payload_bitrate_meter: per-PID payload byte meter with bitrate report
// Packet: match, accumulate when counted, packet output, then the output register.
// Report: per active slot a 19-step multiply and a 64-step divide on one adder.
// Output stalls hold the sequencer in its output state; in_ready is low until it is back in idle.
// Reset clears configuration registers, state, byte counters and handshakes at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ts_pid_payload_bitrate_meter #(
  parameter int NUM_SLOTS  = 4,
  parameter int COUNT_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [tpbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [7:0]                        sync_byte,
  input  logic [7:0]                        hdr_byte1,
  input  logic [7:0]                        hdr_byte2,
  input  logic [7:0]                        hdr_byte3,
  input  logic [7:0]                        adapt_len,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              kind,
  output logic [1:0]                        slot,
  output logic                              matched,
  output logic [12:0]                       packet_pid,
  output logic [7:0]                        payload_bytes,
  output logic [63:0]                       bitrate,
  output logic                              last
);
  import tpbm_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Configuration registers
  logic [DUR_W-1:0]      duration_ticks;
  logic [2:0]            stream_count;
  logic [12:0]           pid_slot [NUM_SLOTS];
  logic [COUNT_BITS-1:0] byte_count [NUM_SLOTS];

  // Sequencer state
  state_t              state, state_next;
  logic [SLOT_W-1:0]   cur_slot;
  logic [SLOT_W-1:0]   hit_slot;
  logic                pkt_hit;
  logic [12:0]         pkt_pid;
  logic [7:0]          pkt_size;
  logic [NUM_W-1:0]    acc;
  logic [DUR_W-1:0]    rem;
  logic [QUO_W-1:0]    quo;
  logic [STEP_W-1:0]   step;

  // Combinational
  hdr_info_t           hdr;
  alu_op_t             alu_op;
  logic [NUM_W-1:0]    alu_a, alu_b;
  alu_res_t            alu_res;
  logic                match_hit;
  logic [SLOT_W-1:0]   match_slot;
  logic                cur_active;
  logic                rpt_last;
  logic                out_free;
  logic                out_load;
  logic [4:0]          mul_idx;
  logic                pid_wr;
  logic [CFG_IDX_W-1:0] pid_wr_sel;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_hit;

  tpbm_hdr_decode u_decode (
    .sync_byte (sync_byte),
    .hdr_byte1 (hdr_byte1),
    .hdr_byte2 (hdr_byte2),
    .hdr_byte3 (hdr_byte3),
    .adapt_len (adapt_len),
    .info      (hdr)
  );

  tpbm_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign cnt_cur    = byte_count[cur_slot];
  assign cnt_hit    = byte_count[hit_slot];
  assign cur_active = (int'(cur_slot) < int'(stream_count));
  assign rpt_last   = (cur_slot == LAST_SLOT);
  assign out_free   = !out_valid || out_ready;
  assign mul_idx    = MUL_IDX_TOP - step[4:0];
  assign pid_wr     = (cfg_index >= REG_PID_SLOT0) && (cfg_index <= REG_PID_SLOT3);
  assign pid_wr_sel = cfg_index - REG_PID_SLOT0;

  // Slot match, lowest active slot wins; PID zero never matches
  always_comb begin
    match_hit  = 1'b0;
    match_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pid_slot[i] != '0 && pid_slot[i] == pkt_pid && i < int'(stream_count)) begin
        match_hit  = 1'b1;
        match_slot = SLOT_W'(i);
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ticks <= '0;
      stream_count   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pid_slot[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_DURATION) begin
        duration_ticks <= cfg_data[DUR_W-1:0];
      end
      if (cfg_index == REG_STREAM_COUNT) begin
        stream_count <= cfg_data[2:0];
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (pid_wr && int'(pid_wr_sel) == i) begin
          pid_slot[i] <= cfg_data[12:0];
        end
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and shared unit operand select
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    alu_op     = ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (cmd == CMD_REPORT) ? ST_RPT_LOAD : ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_next = (match_hit && pkt_size != '0) ? ST_ACCUM : ST_PKT_OUT;
      end
      ST_ACCUM: begin
        alu_a      = NUM_W'(cnt_hit);
        alu_b      = NUM_W'(pkt_size);
        state_next = ST_PKT_OUT;
      end
      ST_PKT_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RPT_LOAD: begin
        state_next = (cur_active && duration_ticks != '0 && cnt_cur != '0) ?
                     ST_MUL : ST_RPT_OUT;
      end
      ST_MUL: begin
        // MSB-first shift-and-add by the constant
        alu_a = acc << 1;
        alu_b = RATE_MULT[mul_idx] ? NUM_W'(cnt_cur) : '0;
        if (step == MUL_LAST) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        alu_a      = acc;
        alu_b      = NUM_W'(duration_ticks >> 1);
        state_next = ST_SATCHK;
      end
      ST_SATCHK: begin
        // Quotient overflows 64 bits when the top word reaches the divisor
        alu_op     = ALU_SUB;
        alu_a      = NUM_W'(acc[NUM_W-1:QUO_W]);
        alu_b      = NUM_W'(duration_ticks);
        state_next = alu_res.carry ? ST_RPT_OUT : ST_DIV;
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = NUM_W'({rem, acc[QUO_W-1]});
        alu_b  = NUM_W'(duration_ticks);
        if (step == DIV_LAST) begin
          state_next = ST_RPT_OUT;
        end
      end
      ST_RPT_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = rpt_last ? ST_IDLE : ST_RPT_LOAD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Byte counters, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        byte_count[i] <= '0;
      end
    end else if (state == ST_ACCUM) begin
      byte_count[hit_slot] <= (|alu_res.sum[NUM_W-1:COUNT_BITS]) ?
                              COUNT_MAX : alu_res.sum[COUNT_BITS-1:0];
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          pkt_pid  <= hdr.pid;
          pkt_size <= hdr.size;
          cur_slot <= '0;
        end
      end
      ST_MATCH: begin
        pkt_hit  <= match_hit;
        hit_slot <= match_slot;
      end
      ST_RPT_LOAD: begin
        acc  <= '0;
        quo  <= '0;
        step <= '0;
      end
      ST_MUL: begin
        acc  <= alu_res.sum;
        step <= step + 1'b1;
      end
      ST_ROUND: begin
        acc <= alu_res.sum;
      end
      ST_SATCHK: begin
        rem  <= acc[NUM_W-1:QUO_W];
        step <= '0;
        if (alu_res.carry) begin
          quo <= '1;
        end
      end
      ST_DIV: begin
        // Restoring divide, one quotient bit per cycle
        acc  <= acc << 1;
        step <= step + 1'b1;
        quo  <= {quo[QUO_W-2:0], alu_res.carry};
        rem  <= alu_res.carry ? alu_res.sum[DUR_W-1:0] : {rem[DUR_W-2:0], acc[QUO_W-1]};
      end
      ST_RPT_OUT: begin
        if (out_free && !rpt_last) begin
          cur_slot <= cur_slot + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_PKT_OUT) begin
        kind          <= KIND_PACKET;
        slot          <= 2'(hit_slot);
        matched       <= pkt_hit;
        packet_pid    <= pkt_pid;
        payload_bytes <= pkt_size;
        bitrate       <= '0;
        last          <= 1'b1;
      end else begin
        kind          <= KIND_REPORT;
        slot          <= 2'(cur_slot);
        matched       <= cur_active;
        packet_pid    <= '0;
        payload_bytes <= '0;
        bitrate       <= quo;
        last          <= rpt_last;
      end
    end
  end

  // Checks
  `ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_div_rem_below_dur, state == ST_DIV, rem < duration_ticks)
  `ASSERT_IMPL(a_match_has_pid, out_valid && kind == KIND_PACKET && matched, packet_pid != '0)
  `ASSERT_IMPL(a_report_last_slot, out_valid && kind == KIND_REPORT && last,
               slot == 2'(NUM_SLOTS - 1))

endmodule
